[hw/rtl/ccln_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the seven-segment decode for the color level normalizer.
// No dependencies; all other files refer to it by scoped names.
package ccln_pkg;

  // Fixed field widths of the ports
  localparam int SAMPLE_W     = 10;
  localparam int CHAN_W       = 2;
  localparam int LEVEL_W      = 8;
  localparam int SEG_W        = 8;
  localparam int CAL_CHANNELS = 3;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int JOB_SUM_W    = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'hFF;
  localparam logic [SEG_W-1:0]   DP_BIT     = 8'b0000_0001;

  // Register indexes
  localparam logic [2:0] REG_WHITE_RED   = 3'd0;
  localparam logic [2:0] REG_WHITE_GREEN = 3'd1;
  localparam logic [2:0] REG_WHITE_BLUE  = 3'd2;
  localparam logic [2:0] REG_BLACK_RED   = 3'd3;
  localparam logic [2:0] REG_BLACK_GREEN = 3'd4;
  localparam logic [2:0] REG_BLACK_BLUE  = 3'd5;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel_out;
    logic [LEVEL_W-1:0] level;
    logic [SEG_W-1:0]   high_segments;
    logic [SEG_W-1:0]   low_segments;
    logic               cal_error;
  } out_t;

  // One completed group handed from the front to the back
  typedef struct packed {
    logic [CHAN_W-1:0]    channel;
    logic [JOB_SUM_W-1:0] sum;
    logic [SAMPLE_W-1:0]  white;
    logic [SAMPLE_W-1:0]  black;
  } job_t;

  function automatic logic [SEG_W-1:0] seg7(input logic [3:0] nib);
    logic [SEG_W-1:0] s;
    case (nib)
      4'h0: s = 8'b1111_1100;
      4'h1: s = 8'b0110_0000;
      4'h2: s = 8'b1101_1010;
      4'h3: s = 8'b1111_0010;
      4'h4: s = 8'b0110_0110;
      4'h5: s = 8'b1011_0110;
      4'h6: s = 8'b1011_1110;
      4'h7: s = 8'b1110_0000;
      4'h8: s = 8'b1111_1110;
      4'h9: s = 8'b1111_0110;
      4'hA: s = 8'hEE;
      4'hB: s = 8'h3E;
      4'hC: s = 8'h9C;
      4'hD: s = 8'h7A;
      4'hE: s = 8'h9E;
      4'hF: s = 8'h8E;
      default: s = 8'b1111_1100;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/ccln_front.sv]
`timescale 1ns / 1ps
// Front part: accepts samples, keeps per-channel sums and counts, emits a job per group.
// Uses ccln_pkg types.
module ccln_front #(
  parameter int SPL = 16,
  parameter int NCH = 3,
  parameter int SW  = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ccln_pkg::in_t                          in_data,
  input  logic [ccln_pkg::CAL_CHANNELS-1:0][SW-1:0] white,
  input  logic [ccln_pkg::CAL_CHANNELS-1:0][SW-1:0] black,
  input  logic                                   q_full,
  output logic                                   q_push,
  output ccln_pkg::job_t                         q_job
);

  localparam int CNT_W = $clog2(SPL);
  localparam int SUM_W = SW + $clog2(SPL);

  logic [SUM_W-1:0] sum_r   [ccln_pkg::CAL_CHANNELS];
  logic [SUM_W-1:0] sum_nxt [ccln_pkg::CAL_CHANNELS];
  logic [CNT_W-1:0] cnt_r   [ccln_pkg::CAL_CHANNELS];
  logic [CNT_W-1:0] cnt_nxt [ccln_pkg::CAL_CHANNELS];

  logic [ccln_pkg::CHAN_W-1:0] ch;
  logic [SUM_W-1:0]            sum_add;
  logic                        take;
  logic                        done;

  assign in_ready = !q_full;
  assign ch       = in_data.channel;
  // drop channels past NCH or without calibration
  assign take     = in_valid && in_ready &&
                    (32'(ch) < NCH) && (32'(ch) < ccln_pkg::CAL_CHANNELS);

  always_comb begin
    sum_add = '0;
    done    = 1'b0;
    for (int i = 0; i < ccln_pkg::CAL_CHANNELS; i++) begin
      sum_nxt[i] = sum_r[i];
      cnt_nxt[i] = cnt_r[i];
    end
    if (take) begin
      sum_add = sum_r[ch] + SUM_W'(in_data.sample[SW-1:0]);
      done    = (cnt_r[ch] == CNT_W'(SPL - 1));
      if (done) begin
        sum_nxt[ch] = '0;
        cnt_nxt[ch] = '0;
      end else begin
        sum_nxt[ch] = sum_add;
        cnt_nxt[ch] = cnt_r[ch] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccln_pkg::CAL_CHANNELS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ccln_pkg::CAL_CHANNELS; i++) begin
        sum_r[i] <= sum_nxt[i];
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_comb begin
    q_push        = take && done;
    q_job.channel = ch;
    q_job.sum     = ccln_pkg::JOB_SUM_W'(sum_add);
    q_job.white   = ccln_pkg::SAMPLE_W'(white[ch]);
    q_job.black   = ccln_pkg::SAMPLE_W'(black[ch]);
  end

endmodule

[hw/rtl/ccln_queue.sv]
`timescale 1ns / 1ps
// Short job queue between front and back.
// Uses ccln_pkg::job_t and ccln_pkg::QUEUE_DEPTH.
module ccln_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccln_pkg::job_t push_job,
  input  logic           pop,
  output ccln_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int PW = $clog2(ccln_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(ccln_pkg::QUEUE_DEPTH + 1);

  ccln_pkg::job_t mem_r [ccln_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(ccln_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ccln_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/ccln_back.sv]
`timescale 1ns / 1ps
// Back part: averages a group with a reciprocal multiply and normalizes it against
// calibration with a restoring divider, then holds the result in the output register.
// Uses ccln_pkg.
module ccln_back #(
  parameter int SPL = 16,
  parameter int SW  = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ccln_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output ccln_pkg::out_t out_data
);

  localparam int SUM_W = SW + $clog2(SPL);
  localparam int NUM_W = SW + ccln_pkg::LEVEL_W;
  localparam int NW    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DW    = SW;
  localparam int CW    = $clog2(NW + 1);

  // sum / SPL as floor(sum * RM / 2**RS), exact for every SUM_W-bit sum
  localparam int RL   = $clog2(SPL);
  localparam int RS   = SUM_W + RL;
  localparam int RM_W = SUM_W + 1;
  localparam int PW   = 2 * SUM_W + 1;
  localparam logic [RM_W-1:0] RM = RM_W'((1 << RS) / SPL + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [SW-1:0] w_r, w_nxt;
  logic [SW-1:0] b_r, b_nxt;
  logic [ccln_pkg::CHAN_W-1:0] ch_r, ch_nxt;
  logic          err_r, err_nxt;

  logic           ov_r, ov_nxt;
  ccln_pkg::out_t od_r, od_nxt;

  logic [DW:0]    rem_sh;
  logic           ge;
  logic [DW:0]    rem_sub;
  logic [SW-1:0]  avg;
  logic [SW-1:0]  diff;
  logic [ccln_pkg::LEVEL_W-1:0] lvl;
  logic [PW-1:0]  avg_prod;
  logic [SW-1:0]  avg_in;

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // one restoring divide step, plus the reciprocal average and the quotient taps
  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    ge       = (rem_sh >= {1'b0, div_r});
    rem_sub  = rem_sh - {1'b0, div_r};
    avg      = quo_r[SW-1:0];
    diff     = avg - b_r;
    lvl      = quo_r[ccln_pkg::LEVEL_W-1:0];
    avg_prod = PW'(q_job.sum[SUM_W-1:0]) * PW'(RM);
    avg_in   = avg_prod[RS +: SW];
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    w_nxt   = w_r;
    b_nxt   = b_r;
    ch_nxt  = ch_r;
    err_nxt = err_r;
    ov_nxt  = ov_r && !out_ready;
    od_nxt  = od_r;
    q_pop   = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          quo_nxt = NW'(avg_in);
          w_nxt   = q_job.white[SW-1:0];
          b_nxt   = q_job.black[SW-1:0];
          ch_nxt  = q_job.channel;
          st_nxt  = ST_PREP;
        end
      end
      ST_NORM: begin
        quo_nxt = {quo_r[NW-2:0], ge};
        rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_PREP: begin
        err_nxt = 1'b0;
        rem_nxt = '0;
        cnt_nxt = CW'(NW);
        div_nxt = DW'(w_r - b_r);
        if (w_r <= b_r) begin
          err_nxt = 1'b1;
          quo_nxt = '0;
          st_nxt  = ST_DONE;
        end else if (avg <= b_r) begin
          quo_nxt = '0;
          st_nxt  = ST_DONE;
        end else if (avg >= w_r) begin
          // at or above white: saturate
          quo_nxt = NW'(ccln_pkg::FULL_SCALE);
          st_nxt  = ST_DONE;
        end else begin
          // diff * 255 as a shift and subtract
          quo_nxt = NW'({diff, 8'h00}) - NW'(diff);
          st_nxt  = ST_NORM;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt               = 1'b1;
          od_nxt.channel_out   = ch_r;
          od_nxt.level         = lvl;
          od_nxt.high_segments = ccln_pkg::seg7(lvl[7:4]);
          od_nxt.low_segments  = ccln_pkg::seg7(lvl[3:0]) | ccln_pkg::DP_BIT;
          od_nxt.cal_error     = err_r;
          st_nxt               = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    w_r   <= w_nxt;
    b_r   <= b_nxt;
    ch_r  <= ch_nxt;
    err_r <= err_nxt;
    od_r  <= od_nxt;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r.cal_error |-> od_r.level == '0) else $error("cal_error with nonzero level");

  a_dp_set: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> od_r.low_segments[0] && !od_r.high_segments[0])
    else $error("decimal point misplaced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(od_r))
    else $error("result dropped or changed while waiting");

endmodule

[hw/rtl/calibrated_color_level_normalizer.sv]
`timescale 1ns / 1ps
// Timing: a sample that does not end a group is absorbed at its accepting edge; for the
// sample that ends a group the job waits in the queue, then the back part pops it and runs
// PREP, NORM (one divider bit per cycle, NW = max(sample+8, sum) bits) and DONE, or goes
// from PREP straight to DONE when the level clamps or the calibration is unusable.
// Throughput: one sample per cycle while the queue has room; one job in the back at a time.
// Reset (sync, active low) clears sums, counts, queue and output valid; white to full scale.
module calibrated_color_level_normalizer #(
  parameter int SAMPLES_PER_LEVEL = 16,
  parameter int NUM_CHANNELS      = 3,
  parameter int SAMPLE_BITS       = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ccln_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccln_pkg::out_t                      out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ccln_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ccln_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ccln_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // only the low bits of the 10-bit fields are used
  localparam int SW = (SAMPLE_BITS < ccln_pkg::SAMPLE_W) ? SAMPLE_BITS : ccln_pkg::SAMPLE_W;

  logic [ccln_pkg::CAL_CHANNELS-1:0][SW-1:0] white_r, white_nxt;
  logic [ccln_pkg::CAL_CHANNELS-1:0][SW-1:0] black_r, black_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  logic           q_full, q_empty, q_push, q_pop;
  ccln_pkg::job_t push_job, pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    white_nxt = white_r;
    black_nxt = black_r;
    if (wr_en) begin
      case (reg_idx)
        ccln_pkg::REG_WHITE_RED:   white_nxt[0] = pwdata[SW-1:0];
        ccln_pkg::REG_WHITE_GREEN: white_nxt[1] = pwdata[SW-1:0];
        ccln_pkg::REG_WHITE_BLUE:  white_nxt[2] = pwdata[SW-1:0];
        ccln_pkg::REG_BLACK_RED:   black_nxt[0] = pwdata[SW-1:0];
        ccln_pkg::REG_BLACK_GREEN: black_nxt[1] = pwdata[SW-1:0];
        ccln_pkg::REG_BLACK_BLUE:  black_nxt[2] = pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ccln_pkg::REG_WHITE_RED:   prdata = ccln_pkg::CFG_DATA_W'(white_r[0]);
      ccln_pkg::REG_WHITE_GREEN: prdata = ccln_pkg::CFG_DATA_W'(white_r[1]);
      ccln_pkg::REG_WHITE_BLUE:  prdata = ccln_pkg::CFG_DATA_W'(white_r[2]);
      ccln_pkg::REG_BLACK_RED:   prdata = ccln_pkg::CFG_DATA_W'(black_r[0]);
      ccln_pkg::REG_BLACK_GREEN: prdata = ccln_pkg::CFG_DATA_W'(black_r[1]);
      ccln_pkg::REG_BLACK_BLUE:  prdata = ccln_pkg::CFG_DATA_W'(black_r[2]);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r <= '1;
      black_r <= '0;
    end else begin
      white_r <= white_nxt;
      black_r <= black_nxt;
    end
  end

  ccln_front #(
    .SPL (SAMPLES_PER_LEVEL),
    .NCH (NUM_CHANNELS),
    .SW  (SW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .white    (white_r),
    .black    (black_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  ccln_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  ccln_back #(
    .SPL (SAMPLES_PER_LEVEL),
    .SW  (SW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[test/calibrated_color_level_normalizer_checker.sv]
`timescale 1ns / 1ps
// Checker for the color level normalizer: tracks calibration writes and per-channel sums,
// predicts each normalized level and compares it with what the block emits.
// Depends on ccln_pkg for the payload types and register indexes.
module calibrated_color_level_normalizer_checker #(
  parameter int SAMPLES_PER_LEVEL = 16,
  parameter int NUM_CHANNELS      = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ccln_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ccln_pkg::out_t                  out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ccln_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ccln_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              levels_owed,
  output int                              levels_checked
);

  // Segment patterns of hex digits 0..F, digit 0 in the low byte
  localparam logic [127:0] DIGIT_SEGS = {
    8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6, 8'hFE,
    8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  logic [ccln_pkg::SAMPLE_W-1:0] white_lvl [ccln_pkg::CAL_CHANNELS];
  logic [ccln_pkg::SAMPLE_W-1:0] black_lvl [ccln_pkg::CAL_CHANNELS];
  int unsigned                   chan_sum  [ccln_pkg::CAL_CHANNELS];
  int                            chan_count[ccln_pkg::CAL_CHANNELS];
  ccln_pkg::out_t                level_queue[$];
  int                            fail_count;
  int                            pass_count;

  function automatic ccln_pkg::out_t predict_level(input int chan, input int unsigned total);
    int             avg;
    int             span;
    int             q;
    logic [7:0]     lvl;
    ccln_pkg::out_t r;
    avg  = total / SAMPLES_PER_LEVEL;
    span = int'(white_lvl[chan]) - int'(black_lvl[chan]);
    r.cal_error = 1'b0;
    if (span <= 0) begin
      r.cal_error = 1'b1;
      q = 0;
    end else begin
      q = (avg - int'(black_lvl[chan])) * int'(ccln_pkg::FULL_SCALE) / span;
      if (q < 0) q = 0;
      if (q > int'(ccln_pkg::FULL_SCALE)) q = int'(ccln_pkg::FULL_SCALE);
    end
    lvl = q[7:0];
    r.channel_out   = chan[ccln_pkg::CHAN_W-1:0];
    r.level         = lvl;
    r.high_segments = DIGIT_SEGS[lvl[7:4]*8 +: 8];
    r.low_segments  = DIGIT_SEGS[lvl[3:0]*8 +: 8] | ccln_pkg::DP_BIT;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ccln_pkg::out_t exp_r;
    int             c;
    if (!rst_n) begin
      for (int i = 0; i < ccln_pkg::CAL_CHANNELS; i++) begin
        white_lvl[i]  = '1;
        black_lvl[i]  = '0;
        chan_sum[i]   = 0;
        chan_count[i] = 0;
      end
      level_queue.delete();
      fail_count = 0;
      pass_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          ccln_pkg::REG_WHITE_RED:   white_lvl[0] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          ccln_pkg::REG_WHITE_GREEN: white_lvl[1] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          ccln_pkg::REG_WHITE_BLUE:  white_lvl[2] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          ccln_pkg::REG_BLACK_RED:   black_lvl[0] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          ccln_pkg::REG_BLACK_GREEN: black_lvl[1] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          ccln_pkg::REG_BLACK_BLUE:  black_lvl[2] = pwdata[ccln_pkg::SAMPLE_W-1:0];
          default: ;
        endcase
      end

      // Requests on channels past NUM_CHANNELS or without calibration are dropped by the block
      if (in_valid && in_ready && in_data.channel < NUM_CHANNELS &&
          in_data.channel < ccln_pkg::CAL_CHANNELS) begin
        c = int'(in_data.channel);
        chan_sum[c]   += in_data.sample;
        chan_count[c] += 1;
        if (chan_count[c] == SAMPLES_PER_LEVEL) begin
          level_queue.push_back(predict_level(c, chan_sum[c]));
          chan_sum[c]   = 0;
          chan_count[c] = 0;
        end
      end

      if (out_valid && out_ready) begin
        if (level_queue.size() == 0) begin
          $display("%0t: unexpected level, expected none got channel %0d level %0d",
                   $time, out_data.channel_out, out_data.level);
          fail_count++;
        end else begin
          exp_r = level_queue.pop_front();
          check_field("channel_out", exp_r.channel_out, out_data.channel_out);
          check_field("level", exp_r.level, out_data.level);
          check_field("high_segments", exp_r.high_segments, out_data.high_segments);
          check_field("low_segments", exp_r.low_segments, out_data.low_segments);
          check_field("cal_error", exp_r.cal_error, out_data.cal_error);
          pass_count++;
        end
      end
    end
    mismatches     <= fail_count;
    levels_owed    <= level_queue.size();
    levels_checked <= pass_count;
  end

endmodule

[test/calibrated_color_level_normalizer_test.sv]
`timescale 1ns / 1ps
// Top of the color level normalizer testbench: clock, reset, sample and calibration
// stimulus with idle and stall phases, and the final verdict.
// Depends on ccln_pkg, the block and calibrated_color_level_normalizer_checker.
module calibrated_color_level_normalizer_test;

  // Addresses past the last register; writes there must be ignored
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
  localparam int         UNUSED_CHANNEL  = 3;
  localparam int         PHASES          = 8;
  localparam int         SAMPLES_PER_PHASE = 195;
  localparam int         SETTLE_CYCLES   = 60;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  ccln_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  ccln_pkg::out_t                  out_data;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ccln_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ccln_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ccln_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;
  int                              mismatches;
  int                              levels_owed;
  int                              levels_checked;

  int                    tx_idle_pct;
  int                    rx_stall_pct;
  int                    cal_white[ccln_pkg::CAL_CHANNELS];
  int                    cal_black[ccln_pkg::CAL_CHANNELS];
  int                    center[ccln_pkg::CAL_CHANNELS];
  int                    fed[ccln_pkg::CAL_CHANNELS];
  int                    live_samples;
  int                    dropped_samples;

  calibrated_color_level_normalizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  calibrated_color_level_normalizer_checker u_levels_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .levels_owed   (levels_owed),
    .levels_checked(levels_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d levels outstanding", levels_owed);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int clip_sample(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  task automatic feed_sample(input int chan, input int value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.sample  <= value[ccln_pkg::SAMPLE_W-1:0];
    in_data.channel <= chan[ccln_pkg::CHAN_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (chan < ccln_pkg::CAL_CHANNELS) begin
      fed[chan]++;
      live_samples++;
    end else begin
      dropped_samples++;
    end
  endtask

  // Hold the input quiet until every level is out, then give the divider time to settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int value);
    logic [31:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[31:ccln_pkg::SAMPLE_W], value[ccln_pkg::SAMPLE_W-1:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_calibration(input int phase);
    int b;
    for (int c = 0; c < ccln_pkg::CAL_CHANNELS; c++) begin
      case (phase)
        1: begin
          cal_white[c] = 1023;
          cal_black[c] = 0;
        end
        2: begin
          cal_white[c] = 0;
          cal_black[c] = 1023;
        end
        3: begin
          // equal levels, inverted levels, then a usable span
          if (c == 0) begin
            cal_black[c] = $urandom_range(1023);
            cal_white[c] = cal_black[c];
          end else if (c == 1) begin
            cal_black[c] = $urandom_range(1, 1023);
            cal_white[c] = $urandom_range(0, cal_black[c] - 1);
          end else begin
            cal_black[c] = $urandom_range(0, 1000);
            cal_white[c] = $urandom_range(cal_black[c] + 1, 1023);
          end
        end
        4: begin
          cal_black[c] = $urandom_range(0, 1015);
          cal_white[c] = cal_black[c] + $urandom_range(1, 8);
        end
        5: begin
          cal_black[c] = $urandom_range(0, 1022);
          cal_white[c] = $urandom_range(cal_black[c] + 1, 1023);
        end
        6: begin
          if (c == 0) begin
            cal_black[c] = $urandom_range(600, 1000);
            cal_white[c] = $urandom_range(cal_black[c] + 1, 1023);
          end else if (c == 1) begin
            cal_black[c] = $urandom_range(0, 20);
            cal_white[c] = $urandom_range(cal_black[c] + 1, 60);
          end else begin
            cal_black[c] = 0;
            cal_white[c] = 1;
          end
        end
        default: begin
          cal_white[c] = $urandom_range(1023);
          cal_black[c] = $urandom_range(1023);
        end
      endcase
    end
    cfg_write(ccln_pkg::REG_WHITE_RED,   cal_white[0]);
    cfg_write(ccln_pkg::REG_WHITE_GREEN, cal_white[1]);
    cfg_write(ccln_pkg::REG_WHITE_BLUE,  cal_white[2]);
    cfg_write(ccln_pkg::REG_BLACK_RED,   cal_black[0]);
    cfg_write(ccln_pkg::REG_BLACK_GREEN, cal_black[1]);
    cfg_write(ccln_pkg::REG_BLACK_BLUE,  cal_black[2]);
    if (phase == 1) begin
      b = $urandom_range(1023);
      cfg_write(REG_UNMAPPED_LO, b);
      cfg_write(REG_UNMAPPED_HI, 1023 - b);
    end
  endtask

  // Aim each group near black, white, mid span or anywhere so all clamps get hit
  function automatic int next_sample(input int chan);
    int roll;
    if (fed[chan] % 16 == 0) begin
      case ($urandom_range(3))
        0: center[chan] = cal_black[chan] + $urandom_range(16) - 8;
        1: center[chan] = cal_white[chan] + $urandom_range(16) - 8;
        2: center[chan] = (cal_white[chan] + cal_black[chan]) / 2;
        default: center[chan] = $urandom_range(1023);
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 3) return ($urandom_range(1) == 1) ? 1023 : 0;
    if (roll < 13) return $urandom_range(1023);
    return clip_sample(center[chan] + $urandom_range(24) - 12);
  endfunction

  initial begin
    int chan;
    int quota;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    live_samples = 0;
    dropped_samples = 0;
    for (int c = 0; c < ccln_pkg::CAL_CHANNELS; c++) begin
      cal_white[c] = 1023;
      cal_black[c] = 0;
      center[c]    = 512;
      fed[c]       = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused channel, full-scale and zero samples, one red group at mid scale
    feed_sample(UNUSED_CHANNEL, 1023);
    feed_sample(UNUSED_CHANNEL, 0);
    repeat (8) feed_sample(0, 1023);
    repeat (8) feed_sample(0, 0);
    repeat (4) feed_sample(1, 1023);
    repeat (2) feed_sample(2, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase != 0) apply_calibration(phase);
      case (phase % 4)
        0: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct   = 80;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 80;
        end
        default: begin
          tx_idle_pct   = 21;
          rx_stall_pct <= 21;
        end
      endcase
      quota = live_samples + SAMPLES_PER_PHASE;
      while (live_samples < quota) begin
        if ($urandom_range(99) < 5) begin
          feed_sample(UNUSED_CHANNEL, $urandom_range(1023));
        end else begin
          chan = $urandom_range(ccln_pkg::CAL_CHANNELS - 1);
          feed_sample(chan, next_sample(chan));
        end
      end
    end

    drain();
    $display("covered %0d samples on calibrated channels and %0d on the unused one",
             live_samples, dropped_samples);
    $display("%0d levels checked over %0d calibration settings with idle and stall phases",
             levels_checked, PHASES);
    if (levels_owed != 0) $display("%0d levels never arrived", levels_owed);
    if (mismatches == 0 && levels_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ccln_pkg.sv
hw/rtl/ccln_front.sv
hw/rtl/ccln_queue.sv
hw/rtl/ccln_back.sv
hw/rtl/calibrated_color_level_normalizer.sv
test/calibrated_color_level_normalizer_checker.sv
test/calibrated_color_level_normalizer_test.sv
